### src/dual_ipc_fifo_mailbox_assert.svh
// ---------------------------------------------------------------------------
// Mailbox assertion macros
// Shared concurrent-check shorthands; the enclosing module provides clk and
// arst_n.
// ---------------------------------------------------------------------------
`ifndef DUAL_IPC_FIFO_MAILBOX_ASSERT_SVH
`define DUAL_IPC_FIFO_MAILBOX_ASSERT_SVH

// Check that a condition holds at every clock edge outside reset.
`define DIPC_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define DIPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/dipc_pkg.sv
// ---------------------------------------------------------------------------
// Mailbox package
// Types, register bit positions and masks shared by the mailbox modules.
// ---------------------------------------------------------------------------
package dipc_pkg;

	localparam int FIFO_DEPTH = 16;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
	localparam int ADDR_W     = $clog2(2 * FIFO_DEPTH);

	// Access codes
	localparam logic [1:0] CMD_SEND = 2'd0;
	localparam logic [1:0] CMD_RECV = 2'd1;
	localparam logic [1:0] CMD_CTRL = 2'd2;

	// Control/status bit positions
	localparam int ST_SEND_EMPTY = 0;
	localparam int ST_SEND_FULL  = 1;
	localparam int ST_SEND_IRQEN = 2;
	localparam int ST_SEND_CLEAR = 3;
	localparam int ST_RECV_EMPTY = 8;
	localparam int ST_RECV_FULL  = 9;
	localparam int ST_RECV_IRQEN = 10;
	localparam int ST_ERROR      = 14;
	localparam int ST_ENABLE     = 15;

	localparam logic [15:0] MASK_SEND_SIDE = 16'hBFFC;
	localparam logic [15:0] MASK_RECV_SIDE = 16'hBCFF;
	localparam logic [15:0] ST_WRITABLE    = 16'h8404;
	localparam logic [15:0] ST_RESET       = 16'h0101;

	typedef struct packed {
		logic [1:0]  command;
		logic        side;
		logic [31:0] data_word;
	} dipc_req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [15:0] status_side0;
		logic [15:0] status_side1;
		logic [1:0]  irq_send_empty;
		logic [1:0]  irq_recv_nonempty;
	} dipc_rsp_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;     // capture the request
		logic exec;     // carry out the captured access
		logic respond;  // present the result
	} dipc_ctl_t;

endpackage

### src/dipc_ctrl.sv
// ---------------------------------------------------------------------------
// Mailbox controller
// Sequences capture, execution and result strobe of one access.
// ---------------------------------------------------------------------------
`include "dual_ipc_fifo_mailbox_assert.svh"

module dipc_ctrl import dipc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	output logic      done,
	output dipc_ctl_t ctl
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_RESP = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign busy   = (state_q == ST_EXEC);
	assign accept = start && !busy;

	always_comb begin
		case (state_q)
			ST_IDLE: state_d = accept ? ST_EXEC : ST_IDLE;
			ST_EXEC: state_d = ST_RESP;
			ST_RESP: state_d = accept ? ST_EXEC : ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign ctl.load    = accept;
	assign ctl.exec    = (state_q == ST_EXEC);
	assign ctl.respond = (state_q == ST_RESP);
	assign done        = ctl.respond;

	`DIPC_ASSERT_NEXT(a_accept_exec, accept, state_q == ST_EXEC, "accept not followed by exec")
	`DIPC_ASSERT_NEXT(a_exec_resp, ctl.exec, done, "exec not followed by result strobe")
	`DIPC_ASSERT_ALWAYS(a_onehot, $onehot(state_q), "state not one-hot")

endmodule

### src/dipc_datapath.sv
// ---------------------------------------------------------------------------
// Mailbox datapath
// FIFO storage, pointers, fill counts and control/status registers.
// ---------------------------------------------------------------------------
`include "dual_ipc_fifo_mailbox_assert.svh"

module dipc_datapath import dipc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  dipc_ctl_t ctl,
	input  dipc_req_t req,
	output dipc_rsp_t rsp
);

	logic [31:0] mem [2*FIFO_DEPTH];

	dipc_req_t   req_q;
	logic [15:0] cs0_q, cs1_q;
	logic [PTR_W-1:0] head0_q, head1_q, tail0_q, tail1_q;
	logic [CNT_W-1:0] cnt0_q, cnt1_q;
	logic [1:0]  irq_se_q, irq_rn_q;
	logic [31:0] rd_q;
	logic        rd_ok_q;

	logic             s;
	logic [15:0]      own_cs, oth_cs, own_nx, oth_nx;
	logic [PTR_W-1:0] own_tail, oth_head, own_tail_nx, oth_head_nx;
	logic [CNT_W-1:0] own_cnt, oth_cnt, own_cnt_nx, oth_cnt_nx;
	logic             own_clr;
	logic [1:0]       irq_se_d, irq_rn_d;
	logic             wr_en, rd_en;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic [15:0]      v;

	assign s        = req_q.side;
	assign own_cs   = s ? cs1_q : cs0_q;
	assign oth_cs   = s ? cs0_q : cs1_q;
	assign own_tail = s ? tail1_q : tail0_q;
	assign oth_head = s ? head0_q : head1_q;
	assign own_cnt  = s ? cnt1_q : cnt0_q;
	assign oth_cnt  = s ? cnt0_q : cnt1_q;
	assign v        = req_q.data_word[15:0];

	assign wr_addr = ADDR_W'(own_tail) + (s ? ADDR_W'(FIFO_DEPTH) : ADDR_W'(0));
	assign rd_addr = ADDR_W'(oth_head) + (s ? ADDR_W'(0) : ADDR_W'(FIFO_DEPTH));

	always_comb begin
		own_nx      = own_cs;
		oth_nx      = oth_cs;
		own_tail_nx = (own_tail == PTR_W'(FIFO_DEPTH - 1)) ? '0 : own_tail + 1'b1;
		oth_head_nx = (oth_head == PTR_W'(FIFO_DEPTH - 1)) ? '0 : oth_head + 1'b1;
		own_cnt_nx  = own_cnt + 1'b1;
		oth_cnt_nx  = oth_cnt - 1'b1;
		own_clr     = 1'b0;
		wr_en       = 1'b0;
		rd_en       = 1'b0;
		irq_se_d    = '0;
		irq_rn_d    = '0;
		case (req_q.command)
			CMD_SEND: begin
				if (own_cs[ST_ENABLE]) begin
					if (own_cnt == CNT_W'(FIFO_DEPTH)) begin
						own_nx[ST_ERROR] = 1'b1;
					end else begin
						wr_en  = 1'b1;
						own_nx = own_cs & MASK_SEND_SIDE;
						oth_nx = oth_cs & MASK_RECV_SIDE;
						if (own_cnt == CNT_W'(FIFO_DEPTH - 1)) begin
							own_nx[ST_SEND_FULL] = 1'b1;
							oth_nx[ST_RECV_FULL] = 1'b1;
						end
						irq_rn_d[~s] = oth_nx[ST_RECV_IRQEN];
					end
				end
			end
			CMD_RECV: begin
				if (own_cs[ST_ENABLE]) begin
					if (oth_cnt == '0) begin
						own_nx[ST_ERROR] = 1'b1;
					end else begin
						rd_en  = 1'b1;
						own_nx = own_cs & MASK_RECV_SIDE;
						oth_nx = oth_cs & MASK_SEND_SIDE;
						if (oth_cnt == CNT_W'(1)) begin
							own_nx[ST_RECV_EMPTY] = 1'b1;
							oth_nx[ST_SEND_EMPTY] = 1'b1;
							irq_se_d[~s] = oth_nx[ST_SEND_IRQEN];
						end
					end
				end
			end
			CMD_CTRL: begin
				if (v[ST_ERROR]) begin
					own_nx[ST_ERROR] = 1'b0;
				end
				if (v[ST_SEND_CLEAR]) begin
					own_clr               = 1'b1;
					own_nx[ST_SEND_EMPTY] = 1'b1;
					own_nx[ST_SEND_FULL]  = 1'b0;
					oth_nx[ST_RECV_EMPTY] = 1'b1;
					oth_nx[ST_RECV_FULL]  = 1'b0;
				end
				own_nx = (own_nx & ~ST_WRITABLE) | (v & ST_WRITABLE);
				irq_se_d[s] = own_nx[ST_SEND_IRQEN] & own_nx[ST_SEND_EMPTY];
				irq_rn_d[s] = own_nx[ST_RECV_IRQEN] & ~own_nx[ST_RECV_EMPTY];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			req_q <= req;
		end
		if (ctl.exec && wr_en) begin
			mem[wr_addr] <= req_q.data_word;
		end
		if (ctl.exec) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs0_q    <= ST_RESET;
			cs1_q    <= ST_RESET;
			head0_q  <= '0;
			head1_q  <= '0;
			tail0_q  <= '0;
			tail1_q  <= '0;
			cnt0_q   <= '0;
			cnt1_q   <= '0;
			irq_se_q <= '0;
			irq_rn_q <= '0;
			rd_ok_q  <= 1'b0;
		end else if (ctl.exec) begin
			irq_se_q <= irq_se_d;
			irq_rn_q <= irq_rn_d;
			rd_ok_q  <= rd_en;
			if (s) begin
				cs1_q <= own_nx;
				cs0_q <= oth_nx;
			end else begin
				cs0_q <= own_nx;
				cs1_q <= oth_nx;
			end
			// advance the sender's tail on a push
			if (wr_en) begin
				if (s) begin
					tail1_q <= own_tail_nx;
					cnt1_q  <= own_cnt_nx;
				end else begin
					tail0_q <= own_tail_nx;
					cnt0_q  <= own_cnt_nx;
				end
			end
			// advance the other side's head on a pop
			if (rd_en) begin
				if (s) begin
					head0_q <= oth_head_nx;
					cnt0_q  <= oth_cnt_nx;
				end else begin
					head1_q <= oth_head_nx;
					cnt1_q  <= oth_cnt_nx;
				end
			end
			// drop the issuing side's queue contents
			if (own_clr) begin
				if (s) begin
					head1_q <= '0;
					tail1_q <= '0;
					cnt1_q  <= '0;
				end else begin
					head0_q <= '0;
					tail0_q <= '0;
					cnt0_q  <= '0;
				end
			end
		end
	end

	assign rsp.read_data         = rd_ok_q ? rd_q : 32'd0;
	assign rsp.status_side0      = cs0_q;
	assign rsp.status_side1      = cs1_q;
	assign rsp.irq_send_empty    = irq_se_q;
	assign rsp.irq_recv_nonempty = irq_rn_q;

	`DIPC_ASSERT_ALWAYS(a_empty0, cs0_q[ST_SEND_EMPTY] == (cnt0_q == '0), "side 0 empty flag off")
	`DIPC_ASSERT_ALWAYS(a_empty1, cs1_q[ST_SEND_EMPTY] == (cnt1_q == '0), "side 1 empty flag off")
	`DIPC_ASSERT_ALWAYS(a_rempty1, cs1_q[ST_RECV_EMPTY] == (cnt0_q == '0), "side 1 recv flag off")
	`DIPC_ASSERT_ALWAYS(a_full0, cs0_q[ST_SEND_FULL] == (cnt0_q == CNT_W'(FIFO_DEPTH)), "full flag off")

endmodule

### src/dual_ipc_fifo_mailbox.sv
// ---------------------------------------------------------------------------
// Dual inter-processor FIFO mailbox
// Two-sided mailbox with per-side send queues and control/status registers.
// ---------------------------------------------------------------------------
// Usage:
//   Drive request (command, side, data_word) and raise start. The access is
//   taken at the rising edge where start is high and busy is low.
//   The result appears on response in the cycle after the execute cycle,
//   marked by done for exactly one cycle: the access edge, the execute cycle,
//   then the done cycle. busy is high only during the execute cycle, so a
//   new access can transfer while done is high, but busy holds off the next
//   transfer while the captured access executes.
//   Each access yields exactly one result; the receiver cannot stall, so the
//   result must be captured in its done cycle.
//   status_side0/1 show the registers after the access; the interrupt masks
//   are valid with done and hold until the next access executes.
//   Reset clears pointers and fill counts, sets both status registers to
//   0x0101 (both empty, disabled) and returns the controller to idle. Queue
//   storage is not cleared; a receive only reads words that a send wrote.
// ---------------------------------------------------------------------------
module dual_ipc_fifo_mailbox import dipc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  dipc_req_t request,
	output logic      done,
	output dipc_rsp_t response
);

	dipc_ctl_t ctl;

	// Sequence each access: capture, execute, strobe the result
	dipc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctl    (ctl)
	);

	// Hold queue storage and status; update them on execute
	dipc_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.req    (request),
		.rsp    (response)
	);

endmodule
